@@ rtl/core/svt_pkg.sv @@
package svt_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned StepsPerBarDef = 16;
  localparam int unsigned NumPatternsDef = 4;

  // Fixed widths of the register map and of the beat fields.
  localparam int unsigned PatMax  = 4;   // pattern registers in the map
  localparam int unsigned MaskW   = 16;  // step mask bits per pattern
  localparam int unsigned TimeW   = 32;  // millisecond timestamps
  localparam int unsigned DivW    = 16;  // divisor and remainder width
  localparam int unsigned NumW    = 32;  // widest dividend
  localparam int unsigned CntW    = 6;   // divider step counter
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [15:0] OpenTimeReset = 16'd50;

  // Divider run lengths in cycles.
  localparam logic [CntW-1:0] LenShort = CntW'(DivW);
  localparam logic [CntW-1:0] LenLong  = CntW'(NumW);

  // Register indexes (byte address divided by four).
  localparam logic [2:0] RegBarLength = 3'd0;
  localparam logic [2:0] RegStartTime = 3'd1;
  localparam logic [2:0] RegOpenTime  = 3'd2;
  localparam logic [2:0] RegInverted  = 3'd3;
  localparam logic [2:0] RegPattern0  = 3'd4;
  localparam logic [2:0] RegPattern1  = 3'd5;
  localparam logic [2:0] RegPattern2  = 3'd6;
  localparam logic [2:0] RegPattern3  = 3'd7;

  typedef enum logic {
    OpTick   = 1'b0,
    OpSelect = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    StIdle,
    StInt,
    StMod,
    StStep,
    StFin
  } ctrl_state_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [31:0]      now_ms;
    logic [1:0]       pattern_select;
    logic             instant;
  } in_item_t;

  typedef struct packed {
    logic             close_issued;
    logic             open_issued;
    logic             open_pulse_inverted;
    logic             valve_is_open;
    logic [4:0]       step_now;
    logic [1:0]       playing_pattern;
    logic [1:0]       queued_pattern;
  } out_item_t;

  typedef struct packed {
    logic [15:0]                 bar_length;
    logic [TimeW-1:0]            start_time;
    logic [15:0]                 open_time;
    logic                        inverted;
    logic [PatMax-1:0][MaskW-1:0] patterns;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [CntW-1:0]  len;
    logic [NumW-1:0]  dividend;
    logic [DivW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivW-1:0]  quot;
    logic [DivW-1:0]  rem;
  } div_rsp_t;

endpackage

@@ rtl/core/svt_serial_div.sv @@
module svt_serial_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  svt_pkg::div_req_t req_i,
  output svt_pkg::div_rsp_t rsp_o
);
  import svt_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [NumW-1:0]   num_q;
  logic [DivW-1:0]   rem_q;
  logic [DivW-1:0]   den_q;
  logic [DivW+1:0]   trial;
  logic              trial_neg;
  logic [DivW-1:0]   rem_d;

  // One restoring step per cycle: the dividend shifts out at the top of num_q
  // while the quotient bits shift in at the bottom.
  assign trial     = {1'b0, rem_q, num_q[NumW-1]} - {2'b00, den_q};
  assign trial_neg = trial[DivW+1];
  assign rem_d     = trial_neg ? {rem_q[DivW-2:0], num_q[NumW-1]} : trial[DivW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.len;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], ~trial_neg};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q[DivW-1:0];
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/core/svt_cfg_regs.sv @@
module svt_cfg_regs #(
  parameter int unsigned NUM_PATTERNS = svt_pkg::NumPatternsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [svt_pkg::AddrW-1:0] paddr,
  input  logic [svt_pkg::DataW-1:0] pwdata,
  output logic [svt_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output svt_pkg::cfg_t            cfg_o
);
  import svt_pkg::*;

  logic [15:0]       bar_length_q;
  logic [TimeW-1:0]  start_time_q;
  logic [15:0]       open_time_q;
  logic              inverted_q;
  logic [MaskW-1:0]  pattern_q [NUM_PATTERNS];
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_length_q <= '0;
      start_time_q <= '0;
      open_time_q  <= OpenTimeReset;
      inverted_q   <= 1'b0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        pattern_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        RegBarLength: bar_length_q <= pwdata[15:0];
        RegStartTime: start_time_q <= pwdata[TimeW-1:0];
        RegOpenTime:  open_time_q  <= pwdata[15:0];
        RegInverted:  inverted_q   <= pwdata[0];
        default: begin
        end
      endcase
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        if (reg_idx == 3'(RegPattern0 + 3'(i))) begin
          pattern_q[i] <= pwdata[MaskW-1:0];
        end
      end
    end
  end

  // Pattern slots beyond the configured count read as empty masks.
  for (genvar g = 0; g < PatMax; g++) begin : g_pat
    if (g < NUM_PATTERNS) begin : g_used
      assign cfg_o.patterns[g] = pattern_q[g];
    end else begin : g_unused
      assign cfg_o.patterns[g] = '0;
    end
  end

  assign cfg_o.bar_length = bar_length_q;
  assign cfg_o.start_time = start_time_q;
  assign cfg_o.open_time  = open_time_q;
  assign cfg_o.inverted   = inverted_q;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegBarLength: prdata = DataW'(bar_length_q);
      RegStartTime: prdata = DataW'(start_time_q);
      RegOpenTime:  prdata = DataW'(open_time_q);
      RegInverted:  prdata = DataW'(inverted_q);
      RegPattern0, RegPattern1, RegPattern2, RegPattern3: begin
        prdata = DataW'(cfg_o.patterns[reg_idx[1:0]]);
      end
      default: prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/step_sequencer_valve_trigger_core.sv @@
// Flow: a tick beat that runs the step logic passes the interval, modulo and step
// divisions, a tick with a bar shorter than the step count only the interval one,
// a select none. A new beat is taken only once the last one is done; the shared
// bit-serial divider (16 + 32 + 16 steps) runs the divisions one after another.
// Reset: rst_ni clears the controller, the valve and pattern state and loads the
// register defaults (open time 50 ms, everything else zero) at once; no clearing pass.
module step_sequencer_valve_trigger_core #(
  parameter int unsigned STEPS_PER_BAR = svt_pkg::StepsPerBarDef,
  parameter int unsigned NUM_PATTERNS  = svt_pkg::NumPatternsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  svt_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output svt_pkg::out_item_t        out_item_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [svt_pkg::AddrW-1:0] paddr,
  input  logic [svt_pkg::DataW-1:0] pwdata,
  output logic [svt_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import svt_pkg::*;

  // The step index stays below twice the step count, since the interval is the
  // bar length divided by the step count, rounded down.
  localparam int unsigned StepW = $clog2(2 * STEPS_PER_BAR);

  cfg_t          cfg;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  ctrl_state_e   state_q, state_d;
  in_item_t      item_q;
  logic          in_accept;
  logic          fin_fire;

  // Per-beat work registers.
  logic [DivW-1:0]  interval_q;
  logic             run_q;
  logic [StepW-1:0] step_res_q;

  // Sequencer state that persists between beats.
  logic             valve_q, valve_d;
  logic [TimeW-1:0] last_open_q, last_open_d;
  logic [StepW-1:0] cur_step_q, cur_step_d;
  logic [1:0]       active_q, active_d;
  logic [1:0]       pending_q, pending_d;
  logic             sw_pend_q, sw_pend_d;

  // Output register.
  out_item_t        out_q, out_d;
  logic             out_valid_q;

  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] bar_offset;
  logic [7:0]       step_wide;
  logic [MaskW-1:0] mask;
  logic             close_now;
  logic             open_now;

  svt_cfg_regs #(
    .NUM_PATTERNS(NUM_PATTERNS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  svt_serial_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign bar_offset = item_q.now_ms - cfg.start_time;

  // The controller walks a tick through three divisions on the one serial divider:
  // interval = bar / steps, offset within the bar = (now - start) mod bar, and
  // step = offset / interval. A zero interval skips the last two. A select beat
  // goes straight to the finish state, where the sequencer state is updated and
  // the result beat is written once the output register is free.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (in_item_i.opcode == OpTick) ? StInt : StFin;
        end
      end
      StInt: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.quot == '0) ? StFin : StMod;
        end
      end
      StMod: begin
        if (div_rsp.done) begin
          state_d = StStep;
        end
      end
      StStep: begin
        if (div_rsp.done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    fin_fire         = 1'b0;
    div_req.start    = 1'b0;
    div_req.len      = LenShort;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i && (in_item_i.opcode == OpTick)) begin
          div_req.start    = 1'b1;
          div_req.len      = LenShort;
          div_req.dividend = {cfg.bar_length, {(NumW - DivW){1'b0}}};
          div_req.divisor  = DivW'(STEPS_PER_BAR);
        end
      end
      StInt: begin
        if (div_rsp.done && (div_rsp.quot != '0)) begin
          div_req.start    = 1'b1;
          div_req.len      = LenLong;
          div_req.dividend = bar_offset;
          div_req.divisor  = cfg.bar_length;
        end
      end
      StMod: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.len      = LenShort;
          div_req.dividend = {div_rsp.rem, {(NumW - DivW){1'b0}}};
          div_req.divisor  = interval_q;
        end
      end
      StFin: begin
        fin_fire = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // Finish: select handling, close check, step change with pending switch at bar
  // start, and the open decision against the pattern that plays after that switch.
  always_comb begin
    valve_d     = valve_q;
    last_open_d = last_open_q;
    cur_step_d  = cur_step_q;
    active_d    = active_q;
    pending_d   = pending_q;
    sw_pend_d   = sw_pend_q;
    close_now   = 1'b0;
    open_now    = 1'b0;
    step_wide   = 8'(step_res_q);
    elapsed     = item_q.now_ms - last_open_q;
    mask        = '0;

    if (item_q.opcode == OpSelect) begin
      if ({1'b0, item_q.pattern_select} < 3'(NUM_PATTERNS)) begin
        pending_d = item_q.pattern_select;
        if (item_q.instant) begin
          active_d = item_q.pattern_select;
        end else begin
          sw_pend_d = 1'b1;
        end
      end
    end else begin
      if (valve_q && (elapsed >= TimeW'(cfg.open_time))) begin
        valve_d   = 1'b0;
        close_now = 1'b1;
      end
      if (run_q && (step_res_q != cur_step_q)) begin
        cur_step_d = step_res_q;
        if ((step_res_q == '0) && sw_pend_q) begin
          active_d  = pending_q;
          sw_pend_d = 1'b0;
        end
        mask = cfg.patterns[active_d];
        // Steps past the end of the mask never fire.
        if ((step_wide < 8'(MaskW)) && mask[4'(MaskW - 1) - step_wide[3:0]]) begin
          valve_d     = 1'b1;
          last_open_d = item_q.now_ms;
          open_now    = 1'b1;
        end
      end
    end

    out_d.close_issued        = close_now;
    out_d.open_issued         = open_now;
    out_d.open_pulse_inverted = open_now && cfg.inverted;
    out_d.valve_is_open       = valve_d;
    out_d.step_now            = 5'(cur_step_d);
    out_d.playing_pattern     = active_d;
    out_d.queued_pattern      = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valve_q     <= 1'b0;
      last_open_q <= '0;
      cur_step_q  <= '0;
      active_q    <= '0;
      pending_q   <= '0;
      sw_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      run_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        run_q <= 1'b0;
      end else if ((state_q == StInt) && div_rsp.done) begin
        run_q <= (div_rsp.quot != '0);
      end
      if (fin_fire) begin
        valve_q     <= valve_d;
        last_open_q <= last_open_d;
        cur_step_q  <= cur_step_d;
        active_q    <= active_d;
        pending_q   <= pending_d;
        sw_pend_q   <= sw_pend_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    if ((state_q == StInt) && div_rsp.done) begin
      interval_q <= div_rsp.quot;
    end
    if ((state_q == StStep) && div_rsp.done) begin
      step_res_q <= StepW'(div_rsp.quot);
    end
    if (fin_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The divider only reports completion while the controller waits on it.
  a_div_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == StInt) || (state_q == StMod) || (state_q == StStep)))
    else $error("divider finished outside a division state");

  // The step division never runs with a zero interval.
  a_step_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStep) |-> (interval_q != '0))
    else $error("step division started with zero interval");

  // A finished beat waits while the output register is still held.
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFin) && out_valid_q && out_stall_i) |=> (state_q == StFin))
    else $error("result written over a stalled output beat");

  // An open command always leaves the valve open.
  a_open_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.open_issued || out_item_o.valve_is_open))
    else $error("open issued but valve reported closed");

endmodule
